>>> rtl/sfd_pkg.sv
// shared types, phase codes and byte packing helper for the server frame deframer
// no dependencies
package sfd_pkg;

    localparam logic [3:0] PH_HUNT   = 4'd0;
    localparam logic [3:0] PH_CMD    = 4'd1;
    localparam logic [3:0] PH_SID    = 4'd2;
    localparam logic [3:0] PH_CID    = 4'd3;
    localparam logic [3:0] PH_ALEN   = 4'd4;
    localparam logic [3:0] PH_ADDR   = 4'd5;
    localparam logic [3:0] PH_MLEN   = 4'd6;
    localparam logic [3:0] PH_MSG    = 4'd7;
    localparam logic [3:0] PH_SUFFIX = 4'd8;

    localparam logic [1:0] KIND_ADDR     = 2'd0;
    localparam logic [1:0] KIND_MSG      = 2'd1;
    localparam logic [1:0] KIND_END_GOOD = 2'd2;
    localparam logic [1:0] KIND_END_BAD  = 2'd3;

    localparam logic [1:0] CFG_PREFIX     = 2'd0;
    localparam logic [1:0] CFG_SUFFIX     = 2'd1;
    localparam logic [1:0] CFG_BIG_ENDIAN = 2'd2;

    localparam logic [31:0] SID_BYTES  = 32'd4;
    localparam logic [31:0] CID_BYTES  = 32'd8;
    localparam logic [31:0] ALEN_BYTES = 32'd2;
    localparam logic [31:0] MLEN_BYTES = 32'd4;
    localparam logic [15:0] SKIP_MAX   = 16'hFFFF;

    typedef struct packed {
        logic       valid;
        logic [1:0] index;
        logic [7:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic [1:0]  item_kind;
        logic [7:0]  data_byte;
        logic [7:0]  command;
        logic [31:0] server_id;
        logic [63:0] connection_id;
        logic [15:0] address_length;
        logic [31:0] message_length;
        logic [15:0] skipped_count;
    } t_result;

    function automatic logic [63:0] put_byte(
        input logic [63:0] acc,
        input logic [7:0]  b,
        input logic [2:0]  idx,
        input logic        be
    );
        logic [63:0] ret;
        if (be) begin
            ret = {acc[55:0], b};
        end else begin
            ret = acc | ({56'd0, b} << {idx, 3'b000});
        end
        return ret;
    endfunction

endpackage

>>> rtl/sfd_in_if.sv
// input byte channel of the server frame deframer
// no dependencies
interface sfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

>>> rtl/sfd_out_if.sv
// result channel of the server frame deframer
// no dependencies
interface sfd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  item_kind;
    logic [7:0]  data_byte;
    logic [7:0]  command;
    logic [31:0] server_id;
    logic [63:0] connection_id;
    logic [15:0] address_length;
    logic [31:0] message_length;
    logic [15:0] skipped_count;

    modport source (
        output valid, output item_kind, output data_byte, output command,
        output server_id, output connection_id, output address_length,
        output message_length, output skipped_count, input ready
    );
    modport sink (
        input valid, input item_kind, input data_byte, input command,
        input server_id, input connection_id, input address_length,
        input message_length, input skipped_count, output ready
    );
endinterface

>>> rtl/sfd_cfg_if.sv
// configuration write channel of the server frame deframer
// no dependencies
interface sfd_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/sfd_parser.sv
// frame phase tracking, header collection and config registers
// depends on sfd_pkg
module sfd_parser
    import sfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg_wr i_cfg,
    input  logic    i_accept,
    input  logic [7:0] i_byte,
    output logic    o_res_valid,
    output t_result o_res
);

    logic [7:0]  r_prefix, n_prefix;
    logic [7:0]  r_suffix, n_suffix;
    logic        r_be, n_be;
    logic [3:0]  r_phase, n_phase;
    logic [31:0] r_cnt, n_cnt;
    logic [7:0]  r_cmd, n_cmd;
    logic [31:0] r_sid, n_sid;
    logic [63:0] r_cid, n_cid;
    logic [15:0] r_alen, n_alen;
    logic [31:0] r_mlen, n_mlen;
    logic [15:0] r_skip, n_skip;

    always_comb begin
        logic [31:0] cnt_inc;
        logic [63:0] packed_val;
        n_prefix    = r_prefix;
        n_suffix    = r_suffix;
        n_be        = r_be;
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_cmd       = r_cmd;
        n_sid       = r_sid;
        n_cid       = r_cid;
        n_alen      = r_alen;
        n_mlen      = r_mlen;
        n_skip      = r_skip;
        cnt_inc     = r_cnt + 32'd1;
        packed_val  = 64'd0;
        o_res_valid = 1'b0;

        o_res.item_kind      = KIND_ADDR;
        o_res.data_byte      = i_byte;
        o_res.command        = r_cmd;
        o_res.server_id      = r_sid;
        o_res.connection_id  = r_cid;
        o_res.address_length = r_alen;
        o_res.message_length = r_mlen;
        o_res.skipped_count  = r_skip;

        if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_PREFIX:     n_prefix = i_cfg.data;
                CFG_SUFFIX:     n_suffix = i_cfg.data;
                CFG_BIG_ENDIAN: n_be     = i_cfg.data[0];
                default:        ;
            endcase
        end

        if (i_accept) begin
            case (r_phase)
                PH_CMD: begin
                    n_cmd   = i_byte;
                    n_cnt   = 32'd0;
                    n_phase = PH_SID;
                end
                PH_SID: begin
                    packed_val = put_byte({32'd0, r_sid}, i_byte, r_cnt[2:0], r_be);
                    n_sid = packed_val[31:0];
                    n_cnt = cnt_inc;
                    if (cnt_inc >= SID_BYTES) begin
                        n_cnt   = 32'd0;
                        n_phase = PH_CID;
                    end
                end
                PH_CID: begin
                    n_cid = put_byte(r_cid, i_byte, r_cnt[2:0], r_be);
                    n_cnt = cnt_inc;
                    if (cnt_inc >= CID_BYTES) begin
                        n_cnt   = 32'd0;
                        n_phase = PH_ALEN;
                    end
                end
                PH_ALEN: begin
                    packed_val = put_byte({48'd0, r_alen}, i_byte, r_cnt[2:0], r_be);
                    n_alen = packed_val[15:0];
                    n_cnt  = cnt_inc;
                    if (cnt_inc >= ALEN_BYTES) begin
                        n_cnt   = 32'd0;
                        n_phase = (packed_val[15:0] == 16'd0) ? PH_MLEN : PH_ADDR;
                    end
                end
                PH_ADDR: begin
                    o_res_valid     = 1'b1;
                    o_res.item_kind = KIND_ADDR;
                    n_cnt = cnt_inc;
                    if (cnt_inc >= {16'd0, r_alen}) begin
                        n_cnt   = 32'd0;
                        n_phase = PH_MLEN;
                    end
                end
                PH_MLEN: begin
                    packed_val = put_byte({32'd0, r_mlen}, i_byte, r_cnt[2:0], r_be);
                    n_mlen = packed_val[31:0];
                    n_cnt  = cnt_inc;
                    if (cnt_inc >= MLEN_BYTES) begin
                        n_cnt   = 32'd0;
                        n_phase = (packed_val[31:0] == 32'd0) ? PH_SUFFIX : PH_MSG;
                    end
                end
                PH_MSG: begin
                    o_res_valid     = 1'b1;
                    o_res.item_kind = KIND_MSG;
                    n_cnt = cnt_inc;
                    if (cnt_inc >= r_mlen) begin
                        n_cnt   = 32'd0;
                        n_phase = PH_SUFFIX;
                    end
                end
                PH_SUFFIX: begin
                    o_res_valid     = 1'b1;
                    o_res.item_kind = (i_byte == r_suffix) ? KIND_END_GOOD : KIND_END_BAD;
                    n_phase = PH_HUNT;
                    n_cnt   = 32'd0;
                    n_skip  = 16'd0;
                end
                default: begin
                    if (i_byte == r_prefix) begin
                        n_phase = PH_CMD;
                        n_cnt   = 32'd0;
                        n_cmd   = 8'd0;
                        n_sid   = 32'd0;
                        n_cid   = 64'd0;
                        n_alen  = 16'd0;
                        n_mlen  = 32'd0;
                    end else begin
                        n_phase = PH_HUNT;
                        if (r_skip != SKIP_MAX) begin
                            n_skip = r_skip + 16'd1;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix <= 8'd0;
            r_suffix <= 8'd0;
            r_be     <= 1'b1;
            r_phase  <= PH_HUNT;
            r_cnt    <= 32'd0;
            r_cmd    <= 8'd0;
            r_sid    <= 32'd0;
            r_cid    <= 64'd0;
            r_alen   <= 16'd0;
            r_mlen   <= 32'd0;
            r_skip   <= 16'd0;
        end else begin
            r_prefix <= n_prefix;
            r_suffix <= n_suffix;
            r_be     <= n_be;
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_cmd    <= n_cmd;
            r_sid    <= n_sid;
            r_cid    <= n_cid;
            r_alen   <= n_alen;
            r_mlen   <= n_mlen;
            r_skip   <= n_skip;
        end
    end

endmodule

>>> rtl/sfd_out_stage.sv
// result register between the parser and the result channel
// depends on sfd_pkg
module sfd_out_stage
    import sfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_res,
    output logic    o_can_take,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_valid, n_valid;
    t_result r_res, n_res;

    assign o_can_take = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        n_res   = r_res;
        if (o_can_take) begin
            n_valid = i_valid;
            if (i_valid) begin
                n_res = i_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

>>> rtl/server_frame_deframer_top.sv
// top level of the server frame deframer
// depends on sfd_pkg, sfd_in_if, sfd_out_if, sfd_cfg_if, sfd_parser, sfd_out_stage
//
// usage
//   i_in carries one stream byte per request; o_out carries one result per
//   address byte, per message byte and per frame end, each with the header
//   fields of the current frame and the hunt skip count
//   i_cfg writes prefix byte (0), suffix byte (1) and byte order (2); it is
//   always ready; the user must write it only while the block is idle, as the block itself does not enforce this
// timing
//   a byte is taken in every cycle while the result register is empty or
//   being drained; its result is registered and shows on o_out in the cycle after acceptance
//   header bytes and hunted bytes produce no result
// reset
//   synchronous active low; phase returns to hunting, all header fields,
//   counters and the skip count clear, prefix and suffix become 0 and
//   byte order becomes most significant first
// stall
//   when o_out.ready is low with a result held, i_in.ready drops and the
//   held result stays unchanged until it is taken
module server_frame_deframer_top
    import sfd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    sfd_in_if.sink    i_in,
    sfd_cfg_if.sink   i_cfg,
    sfd_out_if.source o_out
);

    t_cfg_wr cfg_wr;
    logic    can_take;
    logic    accept;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr.valid = i_cfg.valid;
    assign cfg_wr.index = i_cfg.index;
    assign cfg_wr.data  = i_cfg.data;

    assign i_in.ready = can_take;
    assign accept     = i_in.valid && can_take;

    sfd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg_wr),
        .i_accept    (accept),
        .i_byte      (i_in.in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    sfd_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (res_valid),
        .i_res      (res),
        .o_can_take (can_take),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_res      (out_res)
    );

    assign o_out.item_kind      = out_res.item_kind;
    assign o_out.data_byte      = out_res.data_byte;
    assign o_out.command        = out_res.command;
    assign o_out.server_id      = out_res.server_id;
    assign o_out.connection_id  = out_res.connection_id;
    assign o_out.address_length = out_res.address_length;
    assign o_out.message_length = out_res.message_length;
    assign o_out.skipped_count  = out_res.skipped_count;

endmodule
